// ===== sv/iba_pkg.sv =====
`default_nettype none
package iba_pkg;
  localparam int NumVals   = 7;
  localparam int MaxBatch  = 64;
  localparam int IdxW      = $clog2(MaxBatch);
  localparam int ValW      = 16;
  localparam int TimeW     = 48;
  localparam int SumW      = ValW + $clog2(MaxBatch);
  localparam int CntW      = 7;

  // register indexes
  localparam logic [1:0] RegInterval = 2'd0;
  localparam logic [1:0] RegBatch    = 2'd1;
  localparam logic [1:0] RegAvgMode  = 2'd2;

  // front-to-back job descriptor
  typedef struct packed {
    logic                     avg;
    logic [8:0]               n;
    logic [NumVals*SumW-1:0]  sums;
  } iba_job_t;
endpackage
`default_nettype wire

// ===== sv/iba_ram.sv =====
`default_nettype none
module iba_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== sv/iba_front.sv =====
`default_nettype none
// Front: accepts samples, keeps sums/count/deadline, writes the store and
// hands finished batches to the back end as job descriptors.
module iba_front (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [iba_pkg::NumVals*iba_pkg::ValW-1:0] vals_i,
  input  wire logic [iba_pkg::TimeW-1:0] ctime_i,
  input  wire logic        read_ok_i,
  input  wire logic [15:0] interval_i,
  input  wire logic [6:0]  batch_size_i,
  input  wire logic        avg_mode_i,
  output logic             we_o,
  output logic [iba_pkg::IdxW-1:0] waddr_o,
  output logic             job_valid_o,
  output iba_pkg::iba_job_t job_o,
  input  wire logic        back_busy_i
);
  import iba_pkg::*;
  localparam int NW = $clog2(MaxBatch + 1);

  logic [NumVals*SumW-1:0] sums_q, sums_d;
  logic [NW-1:0]    cnt_q, cnt_d;
  logic [TimeW-1:0] dl_q, dl_d, dl_cur;
  logic             started_q;
  logic [NW-1:0]    size;
  logic [22:0]      step_w;
  logic [TimeW-1:0] step;
  logic             acc, close;

  // effective batch size
  always_comb begin
    if (batch_size_i == '0) size = NW'(1);
    else if ({1'b0, batch_size_i} > 8'(MaxBatch)) size = NW'(MaxBatch);
    else size = NW'(batch_size_i);
  end

  // back end owns the store while replaying
  assign in_ready_o = !back_busy_i && !job_valid_o;
  assign acc = in_valid_i && in_ready_o;
  assign dl_cur = started_q ? dl_q : ctime_i;
  // 16 x 7 bit deadline step
  assign step_w = 23'(interval_i) * 23'(size);
  assign step = TimeW'(step_w);

  always_comb begin
    sums_d = sums_q;
    cnt_d  = cnt_q;
    we_o   = 1'b0;
    if (read_ok_i) begin
      if (cnt_q < NW'(MaxBatch)) begin
        we_o = acc;
        for (int j = 0; j < NumVals; j++) begin
          sums_d[j*SumW +: SumW] = sums_q[j*SumW +: SumW]
            + SumW'(signed'(vals_i[j*ValW +: ValW]));
        end
        cnt_d = cnt_q + NW'(1);
      end
    end else begin
      sums_d = '0;
      cnt_d  = '0;
    end
    close = (cnt_d >= size) || (ctime_i > dl_cur);
    dl_d = close ? dl_cur + step : dl_cur;
  end
  assign waddr_o = IdxW'(cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sums_q      <= '0;
      cnt_q       <= '0;
      dl_q        <= '0;
      started_q   <= 1'b0;
      job_valid_o <= 1'b0;
      job_o       <= '0;
    end else begin
      job_valid_o <= 1'b0;
      if (acc) begin
        started_q <= 1'b1;
        dl_q      <= dl_d;
        if (close) begin
          sums_q <= '0;
          cnt_q  <= '0;
          if (cnt_d != '0) begin
            job_valid_o <= 1'b1;
            job_o.avg   <= avg_mode_i;
            job_o.n     <= 9'(cnt_d);
            job_o.sums  <= sums_d;
          end
        end else begin
          sums_q <= sums_d;
          cnt_q  <= cnt_d;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== sv/iba_back.sv =====
`default_nettype none
// Back: replays stored samples, or divides the sums serially (restoring,
// one quotient bit per cycle, all seven fields in parallel lanes).
module iba_back (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        job_valid_i,
  input  wire iba_pkg::iba_job_t job_i,
  output logic             busy_o,
  output logic [iba_pkg::IdxW-1:0] raddr_o,
  input  wire logic [iba_pkg::NumVals*iba_pkg::ValW-1:0] rvals_i,
  input  wire logic [iba_pkg::TimeW-1:0] rtime_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [iba_pkg::NumVals*iba_pkg::ValW-1:0] out_vals_o,
  output logic [iba_pkg::TimeW-1:0] out_time_o,
  output logic [6:0]       out_cnt_o,
  output logic             out_last_o
);
  import iba_pkg::*;

  typedef enum logic [2:0] {Idle, Read, Wait, Div, Emit} state_e;
  state_e state_q;
  logic [8:0]  n_q, i_q;
  logic        avg_q;
  logic [4:0]  bit_q;
  logic [SumW-1:0] mag_q [NumVals];
  logic            neg_q [NumVals];
  logic [SumW-1:0] quo_q [NumVals];
  logic [8:0]      rem_q [NumVals];
  logic [9:0]      trial [NumVals];

  assign busy_o  = (state_q != Idle);
  assign raddr_o = avg_q ? IdxW'(n_q - 9'd1) : IdxW'(i_q);

  always_comb begin
    for (int j = 0; j < NumVals; j++) begin
      trial[j] = {rem_q[j], mag_q[j][bit_q]} - {1'b0, n_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= Idle;
      out_valid_o <= 1'b0;
      n_q <= '0; i_q <= '0; avg_q <= 1'b0; bit_q <= '0;
    end else begin
      case (state_q)
        Idle: if (job_valid_i) begin
          n_q <= job_i.n; i_q <= '0; avg_q <= job_i.avg;
          bit_q <= 5'(SumW - 1);
          for (int j = 0; j < NumVals; j++) begin
            neg_q[j] <= job_i.sums[j*SumW + SumW - 1];
            mag_q[j] <= job_i.sums[j*SumW + SumW - 1]
              ? -job_i.sums[j*SumW +: SumW] : job_i.sums[j*SumW +: SumW];
            rem_q[j] <= '0; quo_q[j] <= '0;
          end
          state_q <= job_i.avg ? Div : Read;
        end
        Read: state_q <= Wait; // address settles, RAM registers
        Wait: begin
          // averaged result or replayed sample
          for (int j = 0; j < NumVals; j++) begin
            if (!avg_q) out_vals_o[j*ValW +: ValW] <= rvals_i[j*ValW +: ValW];
            else if (neg_q[j]) out_vals_o[j*ValW +: ValW] <= ValW'(-quo_q[j]);
            else out_vals_o[j*ValW +: ValW] <= ValW'(quo_q[j]);
          end
          out_time_o  <= rtime_i;
          out_cnt_o   <= 7'(n_q);
          out_last_o  <= avg_q || (i_q + 9'd1 == n_q);
          out_valid_o <= 1'b1;
          state_q     <= Emit;
        end
        Div: begin
          for (int j = 0; j < NumVals; j++) begin
            if (!trial[j][9]) begin
              rem_q[j] <= trial[j][8:0];
              quo_q[j] <= {quo_q[j][SumW-2:0], 1'b1};
            end else begin
              rem_q[j] <= {rem_q[j][7:0], mag_q[j][bit_q]};
              quo_q[j] <= {quo_q[j][SumW-2:0], 1'b0};
            end
          end
          if (bit_q == '0) state_q <= Wait;
          else bit_q <= bit_q - 5'd1;
        end
        Emit: if (out_ready_i) begin
          out_valid_o <= 1'b0;
          if (avg_q || out_last_o) state_q <= Idle;
          else begin
            i_q <= i_q + 9'd1;
            state_q <= Read;
          end
        end
        default: state_q <= Idle;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== sv/imu_batch_averager.sv =====
// Sequence: a closing item is registered as a job; a replayed beat is valid
//   after Read and Wait (registered RAM read), again after each beat is taken;
//   an averaged result is valid after the serial divide and Wait.
// Throughput: one sample per cycle while no batch is being emitted; input
//   stalls from a closing item of a non-empty batch until its last beat is taken.
// Reset: rst_ni asynchronous, active low; clears control state and loads register defaults.
`default_nettype none
module imu_batch_averager (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [3:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  wire logic in_valid_i,
  output logic in_ready_o,
  input  wire logic signed [15:0] accel_x_i, accel_y_i, accel_z_i,
  input  wire logic signed [15:0] rate_x_i, rate_y_i, rate_z_i, temp_raw_i,
  input  wire logic [47:0] sample_time_ms_i,
  input  wire logic [47:0] check_time_ms_i,
  input  wire logic read_ok_i,
  output logic out_valid_o,
  input  wire logic out_ready_i,
  output logic signed [15:0] out_accel_x_o, out_accel_y_o, out_accel_z_o,
  output logic signed [15:0] out_rate_x_o, out_rate_y_o, out_rate_z_o, out_temp_o,
  output logic [47:0] out_time_ms_o,
  output logic [6:0] batch_count_o,
  output logic last_o
);
  import iba_pkg::*;

  logic [15:0] interval_q;
  logic [6:0]  batch_q;
  logic        avg_q;
  logic [1:0]  reg_idx;

  // register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= 16'd10; batch_q <= 7'd1; avg_q <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        RegInterval: interval_q <= pwdata[15:0];
        RegBatch:    batch_q    <= pwdata[6:0];
        RegAvgMode:  avg_q      <= pwdata[0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (reg_idx)
      RegInterval: prdata = {16'd0, interval_q};
      RegBatch:    prdata = {25'd0, batch_q};
      RegAvgMode:  prdata = {31'd0, avg_q};
      default:     prdata = '0;
    endcase
  end

  logic [NumVals*ValW-1:0] vals, rvals, ovals;
  logic [TimeW-1:0] rtime;
  logic we, job_valid, busy;
  logic [IdxW-1:0] waddr, raddr;
  iba_job_t job;

  assign vals = {temp_raw_i, rate_z_i, rate_y_i, rate_x_i,
                 accel_z_i, accel_y_i, accel_x_i};

  iba_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .vals_i(vals),
    .ctime_i(check_time_ms_i), .read_ok_i,
    .interval_i(interval_q), .batch_size_i(batch_q), .avg_mode_i(avg_q),
    .we_o(we), .waddr_o(waddr), .job_valid_o(job_valid), .job_o(job),
    .back_busy_i(busy)
  );

  iba_ram #(.Width(NumVals*ValW), .Depth(MaxBatch)) u_vram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(vals),
    .raddr_i(raddr), .rdata_o(rvals)
  );
  iba_ram #(.Width(TimeW), .Depth(MaxBatch)) u_tram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(sample_time_ms_i),
    .raddr_i(raddr), .rdata_o(rtime)
  );

  iba_back u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_i(job), .busy_o(busy),
    .raddr_o(raddr), .rvals_i(rvals), .rtime_i(rtime),
    .out_valid_o, .out_ready_i, .out_vals_o(ovals), .out_time_o(out_time_ms_o),
    .out_cnt_o(batch_count_o), .out_last_o(last_o)
  );

  assign {out_temp_o, out_rate_z_o, out_rate_y_o, out_rate_x_o,
          out_accel_z_o, out_accel_y_o, out_accel_x_o} = ovals;
endmodule
`default_nettype wire

// ===== sv/imu_batch_averager_chk.sv =====
`default_nettype none
module imu_batch_averager_chk (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire logic last_o,
  input wire logic [6:0] batch_count_o
);
  // output beat held while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("out dropped");
  // no sample taken while results are pending
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("in while out");
  // count never zero on a beat
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> batch_count_o != 7'd0) else $error("zero count");
  // single-sample batch is always last
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && batch_count_o == 7'd1 |-> last_o) else $error("last");
endmodule

bind imu_batch_averager imu_batch_averager_chk u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .last_o, .batch_count_o
);
`default_nettype wire

// ===== bench/tb_imu_batch_averager.sv =====
`default_nettype none
module tb_imu_batch_averager;
  timeunit 1ns;
  timeprecision 1ps;
  import iba_pkg::*;

  typedef struct packed {
    logic signed [15:0] ax, ay, az, rx, ry, rz, tp;
    logic [47:0] ts;
    logic [47:0] chk;
    logic ok;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] ax, ay, az, rx, ry, rz, tp;
    logic [47:0] ts;
    logic [6:0] cnt;
    logic lst;
  } batch_out_t;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  sample_t cur;
  logic signed [15:0] o_ax, o_ay, o_az, o_rx, o_ry, o_rz, o_tp;
  logic [47:0] o_ts;
  logic [6:0] o_cnt;
  logic o_last;

  imu_batch_averager DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .accel_x_i(cur.ax), .accel_y_i(cur.ay), .accel_z_i(cur.az),
    .rate_x_i(cur.rx), .rate_y_i(cur.ry), .rate_z_i(cur.rz), .temp_raw_i(cur.tp),
    .sample_time_ms_i(cur.ts), .check_time_ms_i(cur.chk), .read_ok_i(cur.ok),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .out_accel_x_o(o_ax), .out_accel_y_o(o_ay), .out_accel_z_o(o_az),
    .out_rate_x_o(o_rx), .out_rate_y_o(o_ry), .out_rate_z_o(o_rz), .out_temp_o(o_tp),
    .out_time_ms_o(o_ts), .batch_count_o(o_cnt), .last_o(o_last)
  );

  // predictor state
  logic [15:0] cfg_interval;
  logic [6:0] cfg_batch;
  logic cfg_avg;
  logic signed [15:0] vals_mem [MaxBatch][NumVals];
  logic [47:0] times_mem [MaxBatch];
  longint sums [NumVals];
  int unsigned fill;
  logic [47:0] deadline;
  logic armed;

  sample_t pending_samples[$];
  batch_out_t expected_beats[$];
  int errors;
  int unsigned cycles;
  int send_idle_pct, recv_stall_pct;

  task automatic report(input string what);
    $display("MISMATCH: %s at cycle %0d", what, cycles);
    errors++;
  endtask

  // model one accepted sample
  task automatic predict_batch(input sample_t s);
    int unsigned size;
    int unsigned n;
    logic signed [15:0] v [NumVals];
    batch_out_t r;
    size = (cfg_batch == 0) ? 1 : (cfg_batch > MaxBatch) ? MaxBatch : cfg_batch;
    if (!armed) begin
      deadline = s.chk;
      armed = 1'b1;
    end
    v = '{s.ax, s.ay, s.az, s.rx, s.ry, s.rz, s.tp};
    if (s.ok) begin
      if (fill < MaxBatch) begin
        for (int j = 0; j < NumVals; j++) begin
          vals_mem[fill][j] = v[j];
          sums[j] += v[j];
        end
        times_mem[fill] = s.ts;
        fill++;
      end
    end else begin
      fill = 0;
      foreach (sums[j]) sums[j] = 0;
    end
    if (fill >= size || s.chk > deadline) begin
      n = fill;
      if (n > 0) begin
        if (cfg_avg) begin
          r.ax = 16'(sums[0] / longint'(n)); r.ay = 16'(sums[1] / longint'(n));
          r.az = 16'(sums[2] / longint'(n)); r.rx = 16'(sums[3] / longint'(n));
          r.ry = 16'(sums[4] / longint'(n)); r.rz = 16'(sums[5] / longint'(n));
          r.tp = 16'(sums[6] / longint'(n));
          r.ts = times_mem[n-1]; r.cnt = 7'(n); r.lst = 1'b1;
          expected_beats.push_back(r);
        end else begin
          for (int i = 0; i < n; i++) begin
            r.ax = vals_mem[i][0]; r.ay = vals_mem[i][1]; r.az = vals_mem[i][2];
            r.rx = vals_mem[i][3]; r.ry = vals_mem[i][4]; r.rz = vals_mem[i][5];
            r.tp = vals_mem[i][6];
            r.ts = times_mem[i]; r.cnt = 7'(n); r.lst = (i + 1 == n);
            expected_beats.push_back(r);
          end
        end
      end
      fill = 0;
      foreach (sums[j]) sums[j] = 0;
      deadline = 48'(deadline + 48'(cfg_interval) * 48'(size));
    end
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // input driver
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) predict_batch(cur);
    if (!in_valid_i || in_ready_o) begin
      if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        cur <= pending_samples.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result monitor
  always @(posedge clk_i) begin
    batch_out_t e;
    cycles <= cycles + 1;
    if (out_valid_o && out_ready_i) begin
      if (expected_beats.size() == 0) begin
        report("unexpected beat");
      end else begin
        e = expected_beats.pop_front();
        if (o_ax !== e.ax) report($sformatf("accel_x %0d exp %0d", o_ax, e.ax));
        if (o_ay !== e.ay) report($sformatf("accel_y %0d exp %0d", o_ay, e.ay));
        if (o_az !== e.az) report($sformatf("accel_z %0d exp %0d", o_az, e.az));
        if (o_rx !== e.rx) report($sformatf("rate_x %0d exp %0d", o_rx, e.rx));
        if (o_ry !== e.ry) report($sformatf("rate_y %0d exp %0d", o_ry, e.ry));
        if (o_rz !== e.rz) report($sformatf("rate_z %0d exp %0d", o_rz, e.rz));
        if (o_tp !== e.tp) report($sformatf("temp %0d exp %0d", o_tp, e.tp));
        if (o_ts !== e.ts) report($sformatf("time %0h exp %0h", o_ts, e.ts));
        if (o_cnt !== e.cnt) report($sformatf("count %0d exp %0d", o_cnt, e.cnt));
        if (o_last !== e.lst) report($sformatf("last %0b exp %0b", o_last, e.lst));
      end
    end
    if (cycles > 3000000) begin
      $display("tb_imu_batch_averager: errors");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val; penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      RegInterval: cfg_interval = val[15:0];
      RegBatch:    cfg_batch = val[6:0];
      RegAvgMode:  cfg_avg = val[0];
      default: ;
    endcase
  endtask

  // let all queued samples drain and the block go idle
  task automatic drain();
    while (pending_samples.size() > 0 || in_valid_i || expected_beats.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // time base for stimulus; advances so deadlines stay reachable
  logic [47:0] now_ms;

  function automatic sample_t rand_sample(input int ok_pct, input int step_max);
    sample_t s;
    s.ax = 16'($urandom); s.ay = 16'($urandom); s.az = 16'($urandom);
    s.rx = 16'($urandom); s.ry = 16'($urandom); s.rz = 16'($urandom);
    s.tp = 16'($urandom);
    now_ms = now_ms + 48'($urandom_range(step_max));
    s.ts = 48'({$urandom, $urandom});
    if ($urandom_range(3) != 0) s.ts = now_ms;
    s.chk = now_ms;
    s.ok = ($urandom_range(99) < ok_pct);
    return s;
  endfunction

  task automatic push_random(input int count, input int ok_pct, input int step_max);
    repeat (count) pending_samples.push_back(rand_sample(ok_pct, step_max));
  endtask

  initial begin
    sample_t s;
    errors = 0; cycles = 0; fill = 0; deadline = '0; armed = 1'b0;
    foreach (sums[j]) sums[j] = 0;
    cfg_interval = 16'd10; cfg_batch = 7'd1; cfg_avg = 1'b0;
    send_idle_pct = 0; recv_stall_pct = 0; now_ms = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid_i = 1'b0; out_ready_i = 1'b1; cur = '0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset config, extremes of fields
    s = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
          48'hffff_ffff_ffff, 48'd0, 1'b1};
    pending_samples.push_back(s);
    s = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
          48'd0, 48'd5, 1'b1};
    pending_samples.push_back(s);
    drain();

    // averaging of extremes, truncation toward zero, failed read, timeout
    write_reg(RegBatch, 32'd3);
    write_reg(RegAvgMode, 32'd1);
    write_reg(RegInterval, 32'd1);
    s = '{-16'sd7, 16'sd7, -16'sd32768, 16'sd32767, -16'sd1, 16'sd1, 16'sd0,
          48'd100, 48'd6, 1'b1};
    pending_samples.push_back(s);
    s.ax = -16'sd32768; s.ay = 16'sd32767; s.ts = 48'd101; s.chk = 48'd7;
    pending_samples.push_back(s);
    s.ok = 1'b0; s.chk = 48'd7;                 // discard
    pending_samples.push_back(s);
    s.ok = 1'b1; s.chk = 48'd40; s.ts = 48'd102; // timeout with one sample
    pending_samples.push_back(s);
    s.ok = 1'b0; s.chk = 48'd200;               // empty batch on timeout
    pending_samples.push_back(s);
    repeat (3) begin
      s = rand_sample(100, 0);
      s.chk = 48'd200;
      pending_samples.push_back(s);
    end
    drain();

    // batch size zero and above max, zero interval, deadline wrap
    write_reg(RegBatch, 32'd0);
    write_reg(RegInterval, 32'd0);
    write_reg(RegAvgMode, 32'd0);
    s = rand_sample(100, 0); s.chk = 48'd200; pending_samples.push_back(s);
    drain();
    write_reg(RegBatch, 32'd127);
    write_reg(RegInterval, 32'd65535);
    now_ms = 48'd200;
    push_random(70, 100, 0);
    drain();
    write_reg(RegAvgMode, 32'd1);
    push_random(66, 100, 0);
    s = rand_sample(100, 0); s.chk = 48'hffff_ffff_ffff; pending_samples.push_back(s);
    drain();

    // lower batch size mid-batch
    write_reg(RegAvgMode, 32'd0);
    write_reg(RegBatch, 32'd40);
    write_reg(RegInterval, 32'd50000);
    now_ms = 48'hffff_ffff_ff00;
    push_random(5, 100, 0);
    drain();
    write_reg(RegBatch, 32'd2);
    push_random(2, 100, 0);
    drain();

    // random phases with different idling and settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      write_reg(RegInterval, (ph == 5) ? 32'd65535 : 32'($urandom_range(1, 20)));
      write_reg(RegBatch, (ph == 3) ? 32'd64 : 32'($urandom_range(1, 8)));
      write_reg(RegAvgMode, 32'(ph[0]));
      push_random(36, 92, 6);
      drain();
    end
    send_idle_pct = 8; recv_stall_pct = 8;

    drain();
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_imu_batch_averager: clean");
    end else begin
      $display("tb_imu_batch_averager: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== imu_batch_averager.f =====
sv/iba_pkg.sv
sv/iba_ram.sv
sv/iba_front.sv
sv/iba_back.sv
sv/imu_batch_averager.sv
sv/imu_batch_averager_chk.sv
bench/tb_imu_batch_averager.sv
